// ===== rtl/ttsi_pkg.sv =====
// Package for the streaming text-to-signed-integer parser.
// Holds payload structs, phase and status codes, character constants and
// the small character classification functions. Depends on nothing.
package ttsi_pkg;

  localparam int unsigned AccW             = 64;
  localparam int unsigned BaseW            = 6;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned EndW             = 16;
  localparam int unsigned StatusW          = 2;
  localparam int unsigned IndexBitsDefault = 16;

  localparam logic [BaseW-1:0] BaseReset = 6'd10;
  localparam logic [BaseW-1:0] BaseAuto  = 6'd0;
  localparam logic [BaseW-1:0] BaseMin   = 6'd2;
  localparam logic [BaseW-1:0] BaseMax   = 6'd36;
  localparam logic [BaseW-1:0] BaseOct   = 6'd8;
  localparam logic [BaseW-1:0] BaseDec   = 6'd10;
  localparam logic [BaseW-1:0] BaseHex   = 6'd16;
  localparam logic [BaseW-1:0] NoDigit   = 6'd63;

  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpF   = 8'h46;
  localparam logic [ByteW-1:0] ChUpX   = 8'h58;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;
  localparam logic [ByteW-1:0] ChLoA   = 8'h61;
  localparam logic [ByteW-1:0] ChLoF   = 8'h66;
  localparam logic [ByteW-1:0] ChLoX   = 8'h78;
  localparam logic [ByteW-1:0] ChLoZ   = 8'h7A;
  // Letters count from ten: 'A' - 10 and 'a' - 10.
  localparam logic [ByteW-1:0] UpOffset = 8'd55;
  localparam logic [ByteW-1:0] LoOffset = 8'd87;

  typedef enum logic [2:0] {
    PhSpace  = 3'd0,
    PhSigned = 3'd1,
    PhZero   = 3'd2,
    PhXSeen  = 3'd3,
    PhDigits = 3'd4,
    PhDone   = 3'd5
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StNoConv = 2'd1,
    StRange  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             last_byte;
  } ttsi_in_t;

  typedef struct packed {
    logic signed [AccW-1:0] value;
    logic [EndW-1:0]        end_index;
    logic [StatusW-1:0]     status;
  } ttsi_out_t;

  function automatic logic [BaseW-1:0] digit_value(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    d = {ByteW{1'b1}};
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = c - UpOffset;
    end else if (c >= ChLoA && c <= ChLoZ) begin
      d = c - LoOffset;
    end
    return (d == {ByteW{1'b1}}) ? NoDigit : d[BaseW-1:0];
  endfunction

  function automatic logic is_hex(input logic [ByteW-1:0] c);
    return (c >= ChZero && c <= ChNine) || (c >= ChUpA && c <= ChUpF) ||
           (c >= ChLoA && c <= ChLoF);
  endfunction

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic base_ok(input logic [BaseW-1:0] b);
    return (b >= BaseMin) && (b <= BaseMax);
  endfunction

endpackage

// ===== rtl/ttsi_accum.sv =====
// Digit multiply-add with range check against the signed 64-bit limit.
// Purely combinational; uses ttsi_pkg.
module ttsi_accum
  import ttsi_pkg::*;
(
  input  logic [AccW-1:0]  acc_i,
  input  logic [BaseW-1:0] base_i,
  input  logic [BaseW-1:0] digit_i,
  input  logic             negative_i,
  output logic [AccW-1:0]  sum_o,
  output logic             over_o
);

  localparam int unsigned MacW = AccW + BaseW + 1;

  logic [MacW-1:0] prod;
  logic [MacW-1:0] mac;
  logic [AccW-1:0] limit;

  // A 64 by 6 bit product; the upper operand bits are zero.
  assign prod  = MacW'(acc_i) * MacW'(base_i);
  assign mac   = prod + MacW'(digit_i);
  assign limit = negative_i ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};

  // acc*base+digit above the limit is exactly the classic cutoff test.
  assign over_o = mac > MacW'(limit);
  assign sum_o  = mac[AccW-1:0];

endmodule

// ===== rtl/ttsi_parser.sv =====
// Per-string parse state: phase machine, sign, base, accumulator, positions.
// Produces the result for a byte marked last. Uses ttsi_pkg and ttsi_accum.
module ttsi_parser
  import ttsi_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  ttsi_in_t         item_i,
  input  logic [BaseW-1:0] number_base_i,
  output ttsi_out_t        result_o
);

  phase_e                phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [BaseW-1:0]      active_q, active_d;
  logic [AccW-1:0]       acc_q, acc_d;
  logic                  digits_q, digits_d;
  logic                  ovf_q, ovf_d;
  logic [IndexBits-1:0]  pos_q, pos_d;
  logic [IndexBits-1:0]  stop_q, stop_d;

  logic [ByteW-1:0]      c;
  logic [BaseW-1:0]      dig;
  logic                  c_space, c_sign, c_x, c_hex;
  logic                  zero_pfx, first_char, do_take, take_stop;
  logic [BaseW-1:0]      eff_base, take_base;
  logic [AccW-1:0]       mac_sum;
  logic                  mac_over;
  logic [IndexBits-1:0]  stop_final;
  logic [EndW+IndexBits-1:0] stop_ext;

  assign c        = item_i.text_byte;
  assign dig      = digit_value(c);
  assign c_space  = is_space(c);
  assign c_sign   = (c == ChPlus) || (c == ChMinus);
  assign c_x      = (c == ChLoX) || (c == ChUpX);
  assign c_hex    = is_hex(c);

  assign first_char = ((phase_q == PhSpace) && !c_space && !c_sign) ||
                      (phase_q == PhSigned);
  assign zero_pfx   = ((number_base_i == BaseAuto) || (number_base_i == BaseHex)) &&
                      (c == ChZero);
  assign eff_base   = (number_base_i == BaseAuto) ? BaseDec : number_base_i;
  assign take_base  = first_char ? eff_base : active_q;
  assign do_take    = (first_char && !zero_pfx) || ((phase_q == PhZero) && !c_x) ||
                      (phase_q == PhDigits);
  assign take_stop  = !base_ok(take_base) || (dig >= take_base);

  ttsi_accum u_accum (
    .acc_i      (acc_q),
    .base_i     (take_base),
    .digit_i    (dig),
    .negative_i (neg_q),
    .sum_o      (mac_sum),
    .over_o     (mac_over)
  );

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhSpace: begin
        if (c_space) begin
          phase_d = PhSpace;
        end else if (c_sign) begin
          phase_d = PhSigned;
        end else begin
          phase_d = zero_pfx ? PhZero : (take_stop ? PhDone : PhDigits);
        end
      end
      PhSigned: phase_d = zero_pfx ? PhZero : (take_stop ? PhDone : PhDigits);
      PhZero:   phase_d = c_x ? PhXSeen : (take_stop ? PhDone : PhDigits);
      PhXSeen:  phase_d = c_hex ? PhDigits : PhDone;
      PhDigits: phase_d = take_stop ? PhDone : PhDigits;
      PhDone:   phase_d = PhDone;
      default:  phase_d = PhDone;
    endcase
  end

  // Datapath updates for the current byte.
  always_comb begin
    neg_d    = neg_q;
    active_d = active_q;
    acc_d    = acc_q;
    digits_d = digits_q;
    ovf_d    = ovf_q;
    stop_d   = stop_q;
    pos_d    = (pos_q == {IndexBits{1'b1}}) ? pos_q : pos_q + 1'b1;

    if ((phase_q == PhSpace) && (c == ChMinus)) begin
      neg_d = 1'b1;
    end
    if (first_char && zero_pfx) begin
      active_d = (number_base_i == BaseHex) ? BaseHex : BaseOct;
      digits_d = 1'b1;
      acc_d    = '0;
    end else if (first_char) begin
      active_d = eff_base;
    end
    if (do_take) begin
      if (take_stop) begin
        stop_d = pos_q;
      end else begin
        digits_d = 1'b1;
        if (!ovf_q) begin
          if (mac_over) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = mac_sum;
          end
        end
      end
    end
    if ((phase_q == PhZero) && c_x) begin
      stop_d = pos_q;
    end
    if ((phase_q == PhXSeen) && c_hex) begin
      active_d = BaseHex;
      acc_d    = AccW'(dig);
    end
  end

  // Result for a string that ends with this byte.
  assign stop_final = ((phase_d == PhDone) || (phase_d == PhXSeen)) ? stop_d : pos_d;
  assign stop_ext   = {{EndW{1'b0}}, stop_final};

  always_comb begin
    result_o.value     = '0;
    result_o.end_index = '0;
    result_o.status    = StNoConv;
    if (digits_d) begin
      result_o.end_index = stop_ext[EndW-1:0];
      if (ovf_d) begin
        result_o.value  = neg_d ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        result_o.status = StRange;
      end else begin
        result_o.value  = neg_d ? (AccW'(0) - acc_d) : acc_d;
        result_o.status = StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSpace;
      neg_q    <= 1'b0;
      active_q <= '0;
      acc_q    <= '0;
      digits_q <= 1'b0;
      ovf_q    <= 1'b0;
      pos_q    <= '0;
      stop_q   <= '0;
    end else if (step_i && item_i.last_byte) begin
      phase_q  <= PhSpace;
      neg_q    <= 1'b0;
      active_q <= '0;
      acc_q    <= '0;
      digits_q <= 1'b0;
      ovf_q    <= 1'b0;
      pos_q    <= '0;
      stop_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      active_q <= active_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
      ovf_q    <= ovf_d;
      pos_q    <= pos_d;
      stop_q   <= stop_d;
    end
  end

endmodule

// ===== rtl/text_to_signed_integer_parser_core.sv =====
// Top level of the streaming text-to-signed-integer parser.
// Holds the base register, input register and result register; uses ttsi_pkg
// and ttsi_parser.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | sink      | in_valid_i/in_ready_o | in_req_i  (text_byte, last_byte)
//   out     | source    | out_valid_o/out_ready_i | out_req_o (value, end_index,
//           |           |                      |            status)
//   cfg     | sink      | cfg_we_i, no wait    | cfg_wdata_i (number_base)
//
// One byte is accepted per cycle when nothing stalls. A request is captured in
// the input register, and when it advances the parse state moves on by
// one byte through a 64 by 6 bit multiply-add and a limit compare; this
// loop on the accumulator sets the rate. The result of a byte marked last
// is loaded into the result register when that byte advances, and waits
// there until out_ready_i takes it.
// Reset clears the base to ten and all parse state; payload registers are
// not reset. While a result waits in the result register, ordinary bytes keep
// flowing; only a further byte marked last waits for the result to be taken.
module text_to_signed_integer_parser_core
  import ttsi_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BaseW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ttsi_in_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ttsi_out_t        out_req_o
);

  logic [BaseW-1:0] number_base_q;
  ttsi_in_t         in_q;
  logic             in_valid_q, in_valid_d;
  ttsi_out_t        out_q;
  logic             out_valid_q, out_valid_d;
  ttsi_out_t        result;
  logic             advance;
  logic             in_take;
  logic             out_load;

  // The registered byte moves into the parser unless it closes a string and
  // the result register is still occupied by an untaken result.
  assign advance  = in_valid_q && (!in_q.last_byte || !out_valid_q || out_ready_i);
  assign out_load = advance && in_q.last_byte;

  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  ttsi_parser #(
    .IndexBits (IndexBits)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .number_base_i (number_base_q),
    .result_o      (result)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BaseReset;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        number_base_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
